FILE: hdl/cbq_pkg.sv
// Package for the cascaded biquad filter: defaults, opcodes and coefficient slot codes.
`timescale 1ns / 1ps

package cbq_pkg;

   localparam int MAX_SECTIONS_DEF  = 4;
   localparam int SAMPLE_WIDTH_DEF  = 24;
   localparam int COEF_WIDTH_DEF    = 24;
   localparam int HISTORY_WIDTH_DEF = 48;

   localparam int SLOT_COUNT        = 5;
   localparam int CSR_WIDTH         = 3;
   localparam int SECTION_IDX_WIDTH = 2;
   localparam int SLOT_IDX_WIDTH    = 3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef enum logic [SLOT_IDX_WIDTH-1:0] {
      SLOT_B0,
      SLOT_B1,
      SLOT_B2,
      SLOT_A1,
      SLOT_A2
   } coef_slot_type;

endpackage

FILE: hdl/cascaded_biquad_iir_filter.sv
// Cascaded biquad IIR filter (direct form II transposed) with one shared multiplier.
`timescale 1ns / 1ps

// Usage:
//  req_* channel carries one item per transfer (req_valid high, req_stall low).
//  req_opcode selects a sample item or a coefficient load. A load writes one of
//  b0, b1, b2, a1, a2 of one section and gives no response.
//  A sample runs through the first csr section count sections and gives one
//  rsp_* transfer with the filtered sample, the block end mark and a clip flag.
//  Each section steps through FETCH, MUL_B0, ACC, ROUND, FB1, FB2, UPD and
//  WRITE on the single multiplier: five coefficient reads from the
//  coefficient memory, one history read and one history write. A sample with
//  n sections (n = 0..MAX_SECTIONS) holds the block until its result is
//  in the response register, and only then is the next item taken.
//  The response waits in an output register: a stalled rsp side does not
//  stop the next item from entering, but a finished sample waits for the
//  register to free up before its result is loaded.
//  csr_we writes the section count (values above MAX_SECTIONS use all of them).
//  Reset clears coefficients and history (through per-entry valid bits), sets
//  the section count to 1 and empties the output register.

module cascaded_biquad_iir_filter
   import cbq_pkg::*;
#(
   parameter int MAX_SECTIONS  = MAX_SECTIONS_DEF,
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH    = COEF_WIDTH_DEF,
   parameter int HISTORY_WIDTH = HISTORY_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample_in,
   input  logic                               req_block_end,
   input  logic        [SECTION_IDX_WIDTH-1:0] req_coef_section,
   input  logic        [SLOT_IDX_WIDTH-1:0]   req_coef_slot,
   input  logic signed [COEF_WIDTH-1:0]       req_coef_value,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_sample_out,
   output logic                               rsp_block_end_out,
   output logic                               rsp_clipped,

   input  logic                               csr_we,
   input  logic        [CSR_WIDTH-1:0]        csr_wdata
);

   localparam int H    = HISTORY_WIDTH;
   localparam int S    = SAMPLE_WIDTH;
   localparam int C    = COEF_WIDTH;
   localparam int PW   = S + C;
   localparam int ALN  = H - PW;
   localparam int SHL  = (ALN > 0) ? ALN : 0;
   localparam int SHR  = (ALN < 0) ? -ALN : 0;
   localparam int WW   = PW + SHL + 1;
   localparam longint unsigned RND =
      (SHR > 0) ? (64'd1 << ((SHR > 0) ? SHR - 1 : 0)) : 64'd0;
   localparam int ALN2 = S - H + 2;
   localparam int SHL2 = (ALN2 > 0) ? ALN2 : 0;
   localparam int SHR2 = (ALN2 < 0) ? -ALN2 : 0;
   localparam int WW2  = H + SHL2 + 1;
   localparam longint unsigned RND2 =
      (SHR2 > 0) ? (64'd1 << ((SHR2 > 0) ? SHR2 - 1 : 0)) : 64'd0;
   localparam int ENTRIES = MAX_SECTIONS * SLOT_COUNT;
   localparam int CA   = $clog2(ENTRIES);
   localparam int SA   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL_B0,
      ST_ACC,
      ST_ROUND,
      ST_FB1,
      ST_FB2,
      ST_UPD,
      ST_WRITE,
      ST_DONE
   } state_type;

   function automatic logic signed [H-1:0] sat_hist(input logic signed [H:0] v);
      logic signed [H-1:0] r;
      if (v[H] != v[H-1]) begin
         r = v[H] ? {1'b1, {(H-1){1'b0}}} : {1'b0, {(H-1){1'b1}}};
      end else begin
         r = v[H-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [H-1:0] hadd(input logic signed [H-1:0] a,
                                                 input logic signed [H-1:0] b);
      logic signed [H:0] s;
      s = {a[H-1], a} + {b[H-1], b};
      return sat_hist(s);
   endfunction

   function automatic logic signed [H-1:0] hsub(input logic signed [H-1:0] a,
                                                 input logic signed [H-1:0] b);
      logic signed [H:0] s;
      s = {a[H-1], a} - {b[H-1], b};
      return sat_hist(s);
   endfunction

   // product -> history format, round half up or shift up, saturate
   function automatic logic signed [H-1:0] align_prod(input logic signed [PW-1:0] p);
      logic signed [WW-1:0] w;
      logic signed [WW-1:0] r;
      logic signed [H-1:0]  o;
      w = $signed({{(WW-PW){p[PW-1]}}, p}) <<< SHL;
      w = w + $signed(WW'(RND));
      r = w >>> SHR;
      if (r[WW-1:H-1] != {(WW-H+1){r[WW-1]}}) begin
         o = r[WW-1] ? {1'b1, {(H-1){1'b0}}} : {1'b0, {(H-1){1'b1}}};
      end else begin
         o = r[H-1:0];
      end
      return o;
   endfunction

   // history -> sample format; msb of the result is the clip flag
   function automatic logic [S:0] round_out(input logic signed [H-1:0] v);
      logic signed [WW2-1:0] w;
      logic signed [WW2-1:0] r;
      logic        [S:0]     o;
      w = $signed({{(WW2-H){v[H-1]}}, v}) <<< SHL2;
      w = w + $signed(WW2'(RND2));
      r = w >>> SHR2;
      if (r[WW2-1:S-1] != {(WW2-S+1){r[WW2-1]}}) begin
         o = r[WW2-1] ? {1'b1, 1'b1, {(S-1){1'b0}}} : {1'b1, 1'b0, {(S-1){1'b1}}};
      end else begin
         o = {1'b0, r[S-1:0]};
      end
      return o;
   endfunction

   state_type                state_ff;
   logic [SA-1:0]            sec_ff;
   logic [CA-1:0]            coef_base_ff;
   logic [CSR_WIDTH-1:0]     left_ff;
   logic [CSR_WIDTH-1:0]     section_count_ff;
   logic signed [S-1:0]      x_ff;
   logic signed [S-1:0]      y_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [PW-1:0]     prod_in;
   logic signed [H-1:0]      acc_ff;
   logic signed [H-1:0]      tmp1_ff;
   logic signed [H-1:0]      tmp2_ff;
   logic                     clip_ff;
   logic                     block_end_ff;
   logic                     rsp_valid_ff;
   logic signed [S-1:0]      rsp_sample_out_ff;
   logic                     rsp_block_end_out_ff;
   logic                     rsp_clipped_ff;

   logic [C-1:0]             coef_mem [ENTRIES];
   logic [ENTRIES-1:0]       coef_vld_ff;
   logic [C-1:0]             coef_rd_ff;
   logic                     coef_rd_vld_ff;
   logic [2*H-1:0]           hist_mem [MAX_SECTIONS];
   logic [MAX_SECTIONS-1:0]  hist_vld_ff;
   logic [2*H-1:0]           hist_rd_ff;
   logic                     hist_rd_vld_ff;

   logic                     req_xfer;
   logic                     rsp_load;
   logic                     load_ok;
   logic                     load_we;
   logic [CA-1:0]            load_addr;
   logic [CA-1:0]            coef_raddr;
   logic signed [C-1:0]      coef_eff;
   logic signed [S-1:0]      mul_a;
   logic signed [H-1:0]      prod_al;
   logic signed [H-1:0]      h1;
   logic signed [H-1:0]      h2;
   logic [S:0]               y_pack;
   logic [CSR_WIDTH-1:0]     n_sections;

   assign req_stall         = (state_ff != ST_IDLE);
   assign req_xfer          = req_valid && !req_stall;
   assign rsp_load          = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_out_ff;
   assign rsp_block_end_out = rsp_block_end_out_ff;
   assign rsp_clipped       = rsp_clipped_ff;

   assign load_ok   = (int'(req_coef_section) < MAX_SECTIONS) &&
                      (req_coef_slot < SLOT_IDX_WIDTH'(SLOT_COUNT));
   assign load_we   = req_xfer && (req_opcode == OP_LOAD) && load_ok;
   assign load_addr = CA'(int'(req_coef_section) * SLOT_COUNT + int'(req_coef_slot));

   assign n_sections = (int'(section_count_ff) > MAX_SECTIONS) ?
                       CSR_WIDTH'(MAX_SECTIONS) : section_count_ff;

   always_comb begin
      case (state_ff)
         ST_FETCH:  coef_raddr = coef_base_ff + CA'(SLOT_B0);
         ST_MUL_B0: coef_raddr = coef_base_ff + CA'(SLOT_B1);
         ST_ACC:    coef_raddr = coef_base_ff + CA'(SLOT_B2);
         ST_ROUND:  coef_raddr = coef_base_ff + CA'(SLOT_A1);
         ST_FB1:    coef_raddr = coef_base_ff + CA'(SLOT_A2);
         default:   coef_raddr = coef_base_ff;
      endcase
   end

   assign coef_eff = coef_rd_vld_ff ? $signed(coef_rd_ff) : '0;
   assign mul_a    = ((state_ff == ST_FB1) || (state_ff == ST_FB2)) ? y_ff : x_ff;
   assign prod_in  = $signed({{(PW-S){mul_a[S-1]}}, mul_a}) *
                     $signed({{(PW-C){coef_eff[C-1]}}, coef_eff});
   assign prod_al  = align_prod(prod_ff);
   assign h1       = hist_rd_vld_ff ? $signed(hist_rd_ff[2*H-1:H]) : '0;
   assign h2       = hist_rd_vld_ff ? $signed(hist_rd_ff[H-1:0]) : '0;
   assign y_pack   = round_out(acc_ff);

   // coefficient memory
   always_ff @(posedge clock) begin
      if (load_we) begin
         coef_mem[load_addr] <= req_coef_value;
      end
      coef_rd_ff     <= coef_mem[coef_raddr];
      coef_rd_vld_ff <= coef_vld_ff[coef_raddr];
   end

   // history memory, {h1, h2} per section
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         hist_rd_ff     <= hist_mem[sec_ff];
         hist_rd_vld_ff <= hist_vld_ff[sec_ff];
      end
      if (state_ff == ST_WRITE) begin
         hist_mem[sec_ff] <= {tmp1_ff, tmp2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
      end else begin
         if (load_we) begin
            coef_vld_ff[load_addr] <= 1'b1;
         end
         if (state_ff == ST_WRITE) begin
            hist_vld_ff[sec_ff] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_ff         <= req_sample_in;
               block_end_ff <= req_block_end;
               clip_ff      <= 1'b0;
            end
         end
         ST_ACC: begin
            acc_ff <= hadd(prod_al, h1);
         end
         ST_ROUND: begin
            y_ff    <= y_pack[S-1:0];
            clip_ff <= clip_ff | y_pack[S];
            tmp1_ff <= prod_al;
         end
         ST_FB1: begin
            tmp2_ff <= prod_al;
         end
         ST_FB2: begin
            tmp1_ff <= hsub(tmp1_ff, prod_al);
         end
         ST_UPD: begin
            tmp1_ff <= hadd(tmp1_ff, h2);
            tmp2_ff <= hsub(tmp2_ff, prod_al);
         end
         ST_WRITE: begin
            x_ff <= y_ff;
         end
         default: ;
      endcase
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         section_count_ff <= CSR_WIDTH'(1);
         sec_ff           <= '0;
         coef_base_ff     <= '0;
         left_ff          <= '0;
      end else begin
         if (csr_we) begin
            section_count_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_opcode == OP_SAMPLE)) begin
                  sec_ff       <= '0;
                  coef_base_ff <= '0;
                  left_ff      <= n_sections;
                  state_ff     <= (n_sections == '0) ? ST_DONE : ST_FETCH;
               end
            end
            ST_FETCH:  state_ff <= ST_MUL_B0;
            ST_MUL_B0: state_ff <= ST_ACC;
            ST_ACC:    state_ff <= ST_ROUND;
            ST_ROUND:  state_ff <= ST_FB1;
            ST_FB1:    state_ff <= ST_FB2;
            ST_FB2:    state_ff <= ST_UPD;
            ST_UPD:    state_ff <= ST_WRITE;
            ST_WRITE: begin
               sec_ff       <= sec_ff + SA'(1);
               coef_base_ff <= coef_base_ff + CA'(SLOT_COUNT);
               left_ff      <= left_ff - CSR_WIDTH'(1);
               state_ff     <= (left_ff == CSR_WIDTH'(1)) ? ST_DONE : ST_FETCH;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_sample_out_ff    <= x_ff;
                  rsp_block_end_out_ff <= block_end_ff;
                  rsp_clipped_ff       <= clip_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside of the finish step");

   a_fetch_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (left_ff != '0))
      else $error("section fetch with no sections left");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_opcode == OP_LOAD)) |=> (state_ff == ST_IDLE))
      else $error("coefficient load left the idle state");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("finished sample dropped while the response was stalled");

endmodule
